// ===== design/ssa_pkg.sv =====
package ssa_pkg;

    localparam int DW        = 32;
    localparam int FRAC      = 16;
    localparam int SQW       = 2 * DW;
    localparam int LENW      = DW;
    localparam int QW        = FRAC + 1;
    localparam int ACW       = 31;
    localparam int PRODW     = QW + ACW;
    localparam int NCOMP     = 3;
    localparam int SQRT_LAT  = LENW;
    localparam int DIV_LAT   = QW;

    localparam logic [ACW-1:0] MAX_ACCEL_RST = ACW'(65536);

    typedef logic signed [DW-1:0] t_q;

    // per-item data that rides alongside the square root
    typedef struct packed {
        logic [NCOMP-1:0]         neg;
        logic [NCOMP-1:0][DW-1:0] mag;
    } t_side;

    // per-item flags that ride alongside the dividers
    typedef struct packed {
        logic [NCOMP-1:0] neg;
        logic             zero;
    } t_flag;

endpackage

// ===== design/ssa_in_if.sv =====
interface ssa_in_if import ssa_pkg::*; ();
    logic valid;
    logic ready;
    t_q   target_x;
    t_q   target_y;
    t_q   target_z;
    t_q   pos_x;
    t_q   pos_y;
    t_q   pos_z;
    t_q   vel_x;
    t_q   vel_y;
    t_q   vel_z;

    modport source (
        output valid, target_x, target_y, target_z, pos_x, pos_y, pos_z,
               vel_x, vel_y, vel_z,
        input  ready
    );
    modport sink (
        input  valid, target_x, target_y, target_z, pos_x, pos_y, pos_z,
               vel_x, vel_y, vel_z,
        output ready
    );
endinterface

// ===== design/ssa_out_if.sv =====
interface ssa_out_if import ssa_pkg::*; ();
    logic valid;
    logic ready;
    t_q   accel_x;
    t_q   accel_y;
    t_q   accel_z;

    modport source (output valid, accel_x, accel_y, accel_z, input ready);
    modport sink   (input valid, accel_x, accel_y, accel_z, output ready);
endinterface

// ===== design/ssa_isqrt.sv =====
module ssa_isqrt import ssa_pkg::*; (
    input  logic            i_clk,
    input  logic            i_en,
    input  logic [SQW-1:0]  i_val,
    output logic [LENW-1:0] o_root
);

    logic [SQW-1:0] w_v   [0:SQRT_LAT];
    logic [SQW-1:0] w_res [0:SQRT_LAT];

    assign w_v[0]   = i_val;
    assign w_res[0] = '0;

    // one result bit per stage, bit weight fixed per stage
    for (genvar k = 0; k < SQRT_LAT; k++) begin : g_stage
        localparam logic [SQW-1:0] BIT = SQW'(1) << (SQW - 2 - 2 * k);
        logic [SQW-1:0] trial;
        logic [SQW-1:0] n_v;
        logic [SQW-1:0] n_res;
        logic [SQW-1:0] r_v;
        logic [SQW-1:0] r_res;

        always_comb begin
            trial = w_res[k] + BIT;
            if (w_v[k] >= trial) begin
                n_v   = w_v[k] - trial;
                n_res = (w_res[k] >> 1) + BIT;
            end else begin
                n_v   = w_v[k];
                n_res = w_res[k] >> 1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_v   <= n_v;
                r_res <= n_res;
            end
        end

        assign w_v[k+1]   = r_v;
        assign w_res[k+1] = r_res;
    end

    assign o_root = w_res[SQRT_LAT][LENW-1:0];

endmodule

// ===== design/ssa_div.sv =====
module ssa_div import ssa_pkg::*; (
    input  logic            i_clk,
    input  logic            i_en,
    input  logic [DW-1:0]   i_mag,
    input  logic [LENW-1:0] i_den,
    output logic [QW-1:0]   o_quo
);

    // quotient of (i_mag << FRAC) / i_den, known to fit QW bits
    logic [LENW-1:0] w_rem [0:DIV_LAT];
    logic [QW-1:0]   w_quo [0:DIV_LAT];
    logic [LENW-1:0] w_den [0:DIV_LAT];

    assign w_rem[0] = {1'b0, i_mag[DW-1:1]};
    assign w_quo[0] = '0;
    assign w_den[0] = i_den;

    for (genvar j = 0; j < DIV_LAT; j++) begin : g_stage
        logic            bit_in;
        logic [LENW:0]   shifted;
        logic [LENW-1:0] n_rem;
        logic [QW-1:0]   n_quo;
        logic [LENW-1:0] r_rem;
        logic [QW-1:0]   r_quo;
        logic [LENW-1:0] r_den;

        if (j == 0) begin : g_first
            assign bit_in = i_mag[0];
        end else begin : g_rest
            assign bit_in = 1'b0;
        end

        always_comb begin
            shifted = {w_rem[j], bit_in};
            if (shifted >= {1'b0, w_den[j]}) begin
                n_rem = LENW'(shifted - {1'b0, w_den[j]});
                n_quo = {w_quo[j][QW-2:0], 1'b1};
            end else begin
                n_rem = shifted[LENW-1:0];
                n_quo = {w_quo[j][QW-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem <= n_rem;
                r_quo <= n_quo;
                r_den <= w_den[j];
            end
        end

        assign w_rem[j+1] = r_rem;
        assign w_quo[j+1] = r_quo;
        assign w_den[j+1] = r_den;
    end

    assign o_quo = w_quo[DIV_LAT];

endmodule

// ===== design/seek_steering_accel.sv =====
// Seek steering: per agent, d = (target - pos) - vel with each difference
// saturated to Q16.16, then accel = max_accel * d / |d|, truncated toward zero;
// a zero d gives a zero result. One agent is accepted every cycle while the
// output is not stalled; each passes through differences, squares and sum,
// the one-bit-per-stage square root, the one-bit-per-stage dividers, then the
// scaling multiply and output register. A stall on the output holds the whole
// pipeline. max_accel is written through i_cfg_we/i_cfg_wdata; the user must
// do so only while no beat is in flight, as the block does not enforce it.
module seek_steering_accel import ssa_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    ssa_in_if.sink          i_in,
    ssa_out_if.source       o_out,
    input  logic            i_cfg_we,
    input  logic [ACW-1:0]  i_cfg_wdata
);

    localparam int LAT = 3 + SQRT_LAT + DIV_LAT + 2;

    function automatic t_q sat33(input logic signed [DW:0] v);
        if (v[DW] != v[DW-1]) begin
            sat33 = v[DW] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
        end else begin
            sat33 = v[DW-1:0];
        end
    endfunction

    logic           en;
    logic [LAT-1:0] r_vld;
    logic [ACW-1:0] r_max_accel;

    assign en          = !r_vld[LAT-1] || o_out.ready;
    assign i_in.ready  = en;
    assign o_out.valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_accel <= MAX_ACCEL_RST;
        end else if (i_cfg_we) begin
            r_max_accel <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_in.valid};
        end
    end

    // stage 1: saturated differences
    t_q tgt [NCOMP];
    t_q pos [NCOMP];
    t_q vel [NCOMP];
    t_q n_d [NCOMP];
    t_q r_d [NCOMP];

    assign tgt[0] = i_in.target_x;
    assign tgt[1] = i_in.target_y;
    assign tgt[2] = i_in.target_z;
    assign pos[0] = i_in.pos_x;
    assign pos[1] = i_in.pos_y;
    assign pos[2] = i_in.pos_z;
    assign vel[0] = i_in.vel_x;
    assign vel[1] = i_in.vel_y;
    assign vel[2] = i_in.vel_z;

    always_comb begin
        t_q desired;
        for (int i = 0; i < NCOMP; i++) begin
            desired = sat33({tgt[i][DW-1], tgt[i]} - {pos[i][DW-1], pos[i]});
            n_d[i]  = sat33({desired[DW-1], desired} - {vel[i][DW-1], vel[i]});
        end
    end

    // stage 2: magnitudes and squares
    logic [SQW-1:0] r_sq [NCOMP];
    t_side          r_side2;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < NCOMP; i++) begin
                r_d[i] <= n_d[i];
            end
        end
    end

    t_side side1;
    always_comb begin
        for (int i = 0; i < NCOMP; i++) begin
            side1.neg[i] = r_d[i][DW-1];
            side1.mag[i] = r_d[i][DW-1] ? DW'(~r_d[i] + 1'b1) : DW'(r_d[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side2 <= side1;
            for (int i = 0; i < NCOMP; i++) begin
                r_sq[i] <= SQW'(side1.mag[i]) * SQW'(side1.mag[i]);
            end
        end
    end

    // stage 3: sum of squares
    logic [SQW-1:0] r_sum;
    t_side          r_sline [SQRT_LAT+1];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sum      <= r_sq[0] + r_sq[1] + r_sq[2];
            r_sline[0] <= r_side2;
            for (int k = 1; k <= SQRT_LAT; k++) begin
                r_sline[k] <= r_sline[k-1];
            end
        end
    end

    logic [LENW-1:0] len;

    ssa_isqrt u_isqrt (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_val  (r_sum),
        .o_root (len)
    );

    // side data of the item now leaving the square root
    t_side side_len;
    t_flag flag_len;
    t_flag r_fline [DIV_LAT];

    assign side_len      = r_sline[SQRT_LAT];
    assign flag_len.neg  = side_len.neg;
    assign flag_len.zero = (len == '0);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_fline[0] <= flag_len;
            for (int k = 1; k < DIV_LAT; k++) begin
                r_fline[k] <= r_fline[k-1];
            end
        end
    end

    logic [QW-1:0] quo [NCOMP];

    for (genvar i = 0; i < NCOMP; i++) begin : g_div
        ssa_div u_div (
            .i_clk (i_clk),
            .i_en  (en),
            .i_mag (side_len.mag[i]),
            .i_den (len),
            .o_quo (quo[i])
        );
    end

    // scale by max_accel
    logic [PRODW-1:0] r_prod [NCOMP];
    t_flag            r_fmul;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_fmul <= r_fline[DIV_LAT-1];
            for (int i = 0; i < NCOMP; i++) begin
                r_prod[i] <= PRODW'(quo[i]) * PRODW'(r_max_accel);
            end
        end
    end

    // output register
    t_q r_acc [NCOMP];

    always_ff @(posedge i_clk) begin
        logic [DW-1:0] a;
        if (en) begin
            for (int i = 0; i < NCOMP; i++) begin
                a = r_prod[i][FRAC +: DW];
                if (r_fmul.zero) begin
                    r_acc[i] <= '0;
                end else if (r_fmul.neg[i]) begin
                    r_acc[i] <= DW'(-a);
                end else begin
                    r_acc[i] <= a;
                end
            end
        end
    end

    assign o_out.accel_x = r_acc[0];
    assign o_out.accel_y = r_acc[1];
    assign o_out.accel_z = r_acc[2];

endmodule
